// File: hdl/ihc_pkg.sv
// ihc_pkg: shared types and constants for the ipv4 receive header check
// used by the channel interfaces, the front, the result queue and the top level
package ihc_pkg;

	localparam int unsigned ADDR_W      = 32;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned IDX_W       = 6;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDR  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = 1'd1;

	localparam logic [3:0]  IP_VERSION   = 4'd4;
	localparam logic [5:0]  MIN_HDR_LEN  = 6'd20;
	localparam logic [15:0] MIN_TOT_LEN  = 16'd20;
	localparam logic [IDX_W-1:0] IDX_LAST_FIXED = 6'd19;
	localparam logic [15:0] SUM_GOOD     = 16'hFFFF;

	typedef enum logic [2:0] {
		V_WHOLE       = 3'd0,
		V_FRAGMENT    = 3'd1,
		V_BAD_VERSION = 3'd2,
		V_BAD_HLEN    = 3'd3,
		V_BAD_TLEN    = 3'd4,
		V_BAD_CSUM    = 3'd5,
		V_NOT_OURS    = 3'd6,
		V_TRUNCATED   = 3'd7
	} verdict_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic [15:0] frame_length;
	} in_item_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [7:0]  protocol_number;
		logic [31:0] source_address;
		logic [15:0] ident;
		logic [12:0] fragment_offset;
		logic        more_fragments;
		logic [15:0] datagram_length;
		logic [5:0]  header_bytes;
	} result_t;

	typedef struct packed {
		logic [ADDR_W-1:0] local_address;
		logic [ADDR_W-1:0] subnet_mask;
	} cfg_t;

	typedef struct packed {
		logic    valid;
		result_t item;
	} push_t;

endpackage

// File: hdl/ihc_if.sv
// ihc_in_if, ihc_out_if: valid/ready channels for frame bytes and results
// depends on ihc_pkg for the payload types
interface ihc_in_if;
	logic             valid;
	logic             ready;
	ihc_pkg::in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface ihc_out_if;
	logic            valid;
	logic            ready;
	ihc_pkg::result_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

// File: hdl/ihc_front.sv
// ihc_front: per-byte header capture, ones-complement sum and verdict decision
// depends on ihc_pkg and ihc_in_if; pushes finished results to ihc_queue
module ihc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  ihc_pkg::cfg_t    cfg,
	ihc_in_if.sink           in_ch,
	output ihc_pkg::push_t   push,
	input  logic             push_ready
);

	logic [ihc_pkg::IDX_W-1:0] idx_q;
	logic [5:0]  hl_q;
	logic [15:0] sum_q;
	logic [7:0]  hold_q;
	logic [3:0]  ver_q;
	logic [15:0] tlen_q;
	logic [15:0] ident_q;
	logic [15:0] flags_q;
	logic [7:0]  proto_q;
	logic [63:0] addr_q;
	logic [15:0] flen_q;
	logic        csum_q;
	logic        done_q;

	logic [ihc_pkg::IDX_W-1:0] b_idx, nx_idx;
	logic [5:0]  b_hl;
	logic [15:0] b_sum, nx_sum;
	logic [7:0]  b_hold, nx_hold;
	logic [3:0]  b_ver, nx_ver;
	logic [15:0] b_tlen, nx_tlen;
	logic [15:0] b_ident, nx_ident;
	logic [15:0] b_flags, nx_flags;
	logic [7:0]  b_proto, nx_proto;
	logic [63:0] b_addr, nx_addr;
	logic [15:0] b_flen;
	logic        b_csum, nx_csum;
	logic        b_done, nx_done;

	logic [7:0]  d;
	logic        accept;
	logic [16:0] s17;
	logic        have_v;
	ihc_pkg::verdict_t v;
	logic [31:0] dst;
	logic [31:0] host_part;
	logic        dst_match;
	logic        hdr_end;

	assign accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = push_ready;
	assign d = in_ch.item.data_byte;

	always_comb begin
		if (in_ch.item.first_byte) begin
			b_idx   = '0;
			b_hl    = {in_ch.item.data_byte[3:0], 2'b00};
			b_sum   = '0;
			b_hold  = '0;
			b_ver   = '0;
			b_tlen  = '0;
			b_ident = '0;
			b_flags = '0;
			b_proto = '0;
			b_addr  = '0;
			b_flen  = in_ch.item.frame_length;
			b_csum  = 1'b0;
			b_done  = 1'b0;
		end else begin
			b_idx   = idx_q;
			b_hl    = hl_q;
			b_sum   = sum_q;
			b_hold  = hold_q;
			b_ver   = ver_q;
			b_tlen  = tlen_q;
			b_ident = ident_q;
			b_flags = flags_q;
			b_proto = proto_q;
			b_addr  = addr_q;
			b_flen  = flen_q;
			b_csum  = csum_q;
			b_done  = done_q;
		end
	end

	// field capture by byte position
	always_comb begin
		nx_ver   = b_ver;
		nx_tlen  = b_tlen;
		nx_ident = b_ident;
		nx_flags = b_flags;
		nx_proto = b_proto;
		nx_addr  = b_addr;
		nx_csum  = b_csum;
		nx_hold  = b_hold;
		nx_sum   = b_sum;
		nx_idx   = b_idx;
		s17      = {1'b0, b_sum} + {1'b0, b_hold, d};
		if (!b_done) begin
			case (b_idx) inside
				6'd0: nx_ver = d[7:4];
				6'd2: nx_tlen[15:8] = d;
				6'd3: nx_tlen[7:0] = d;
				6'd4: nx_ident[15:8] = d;
				6'd5: nx_ident[7:0] = d;
				6'd6: nx_flags[15:8] = d;
				6'd7: nx_flags[7:0] = d;
				6'd9: nx_proto = d;
				6'd10, 6'd11: nx_csum = b_csum || (d != 8'd0);
				[6'd12:6'd19]: nx_addr = {b_addr[55:0], d};
				default: nx_addr = b_addr;
			endcase
			if (!b_idx[0]) begin
				nx_hold = d;
			end else begin
				nx_sum = s17[16] ? (s17[15:0] + 16'd1) : s17[15:0];
			end
			if (b_idx != {ihc_pkg::IDX_W{1'b1}}) begin
				nx_idx = b_idx + 1'b1;
			end
		end
	end

	assign dst       = nx_addr[31:0];
	assign host_part = ~cfg.subnet_mask;
	assign dst_match = (dst == 32'hFFFF_FFFF)
		|| (((dst & host_part) == host_part)
			&& ((dst & cfg.subnet_mask) == (cfg.local_address & cfg.subnet_mask)))
		|| (dst == cfg.local_address);
	assign hdr_end = (b_idx >= ihc_pkg::IDX_LAST_FIXED)
		&& (({1'b0, b_idx} + 7'd1) == {1'b0, b_hl});

	always_comb begin
		have_v = 1'b0;
		v      = ihc_pkg::V_TRUNCATED;
		if (!b_done) begin
			if (b_idx == ihc_pkg::IDX_LAST_FIXED) begin
				if (nx_ver != ihc_pkg::IP_VERSION) begin
					have_v = 1'b1;
					v      = ihc_pkg::V_BAD_VERSION;
				end else if (b_hl < ihc_pkg::MIN_HDR_LEN) begin
					have_v = 1'b1;
					v      = ihc_pkg::V_BAD_HLEN;
				end else if (nx_tlen < ihc_pkg::MIN_TOT_LEN || b_flen < nx_tlen) begin
					have_v = 1'b1;
					v      = ihc_pkg::V_BAD_TLEN;
				end
			end
			if (!have_v && hdr_end) begin
				have_v = 1'b1;
				if (nx_csum && nx_sum != ihc_pkg::SUM_GOOD) begin
					v = ihc_pkg::V_BAD_CSUM;
				end else if (!dst_match) begin
					v = ihc_pkg::V_NOT_OURS;
				end else if (nx_flags[12:0] != 13'd0 || nx_flags[13]) begin
					v = ihc_pkg::V_FRAGMENT;
				end else begin
					v = ihc_pkg::V_WHOLE;
				end
			end
			if (!have_v && in_ch.item.last_byte) begin
				have_v = 1'b1;
				v      = ihc_pkg::V_TRUNCATED;
			end
		end
	end

	assign nx_done = b_done || have_v;

	always_comb begin
		push.valid                = accept && have_v;
		push.item.verdict         = v;
		push.item.protocol_number = nx_proto;
		push.item.source_address  = nx_addr[63:32];
		push.item.ident           = nx_ident;
		push.item.fragment_offset = nx_flags[12:0];
		push.item.more_fragments  = nx_flags[13];
		push.item.datagram_length = nx_tlen;
		push.item.header_bytes    = b_hl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			hl_q    <= '0;
			sum_q   <= '0;
			hold_q  <= '0;
			ver_q   <= '0;
			tlen_q  <= '0;
			ident_q <= '0;
			flags_q <= '0;
			proto_q <= '0;
			addr_q  <= '0;
			flen_q  <= '0;
			csum_q  <= 1'b0;
			done_q  <= 1'b1;
		end else if (accept) begin
			idx_q   <= nx_idx;
			hl_q    <= b_hl;
			sum_q   <= nx_sum;
			hold_q  <= nx_hold;
			ver_q   <= nx_ver;
			tlen_q  <= nx_tlen;
			ident_q <= nx_ident;
			flags_q <= nx_flags;
			proto_q <= nx_proto;
			addr_q  <= nx_addr;
			flen_q  <= b_flen;
			csum_q  <= nx_csum;
			done_q  <= nx_done;
		end
	end

endmodule

// File: hdl/ihc_queue.sv
// ihc_queue: small result queue between the front and the output channel
// depends on ihc_pkg and ihc_out_if
module ihc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  ihc_pkg::push_t push,
	output logic           push_ready,
	ihc_out_if.source      out_ch
);

	ihc_pkg::result_t mem_q [ihc_pkg::QUEUE_DEPTH];
	logic [ihc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [ihc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [ihc_pkg::QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready   = (count_q != ihc_pkg::QCNT_W'(ihc_pkg::QUEUE_DEPTH));
	assign do_push      = push.valid && push_ready;
	assign out_ch.valid = (count_q != '0);
	assign out_ch.item  = mem_q[rd_ptr_q];
	assign do_pop       = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/ipv4_rx_header_check.sv
// Receive-side IPv4 header check. Frame bytes arrive one per request in wire order and
// one byte is taken every clock cycle; a frame's verdict (with the captured header
// fields) enters a four-entry result queue at the edge that takes the deciding byte
// and is offered on the output channel next cycle if first in line. Input is held off
// only while that queue is full, so a slow consumer stalls the byte stream after four
// pending results. Configuration writes take effect at the edge after the write.
// depends on ihc_pkg, ihc_if, ihc_front and ihc_queue
module ipv4_rx_header_check (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ihc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ihc_pkg::ADDR_W-1:0]       cfg_data,
	ihc_in_if.sink                           in_ch,
	ihc_out_if.source                        out_ch
);

	ihc_pkg::cfg_t  cfg_q;
	ihc_pkg::push_t push;
	logic           push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_address <= '0;
			cfg_q.subnet_mask   <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				ihc_pkg::REG_LOCAL_ADDR:  cfg_q.local_address <= cfg_data;
				ihc_pkg::REG_SUBNET_MASK: cfg_q.subnet_mask   <= cfg_data;
				default:                  cfg_q <= cfg_q;
			endcase
		end
	end

	ihc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_ch      (in_ch),
		.push       (push),
		.push_ready (push_ready)
	);

	ihc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.out_ch     (out_ch)
	);

endmodule

// File: hdl/ihc_checker.sv
// ihc_checker: port-level assertions for ipv4_rx_header_check, attached by bind
// depends on ihc_pkg
module ihc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input ihc_pkg::result_t  out_item
);

	a_result_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result appeared without an accepted request");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	a_hlen_checked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.verdict != ihc_pkg::V_BAD_VERSION
			&& out_item.verdict != ihc_pkg::V_BAD_HLEN
			&& out_item.verdict != ihc_pkg::V_TRUNCATED
		|-> out_item.header_bytes >= ihc_pkg::MIN_HDR_LEN)
		else $error("verdict past header length check with short header");

	a_good_tlen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.verdict == ihc_pkg::V_WHOLE
			|| out_item.verdict == ihc_pkg::V_FRAGMENT)
		|-> out_item.datagram_length >= ihc_pkg::MIN_TOT_LEN)
		else $error("accepted datagram with short total length");

	a_fragment_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.verdict == ihc_pkg::V_WHOLE
			|| out_item.verdict == ihc_pkg::V_FRAGMENT)
		|-> ((out_item.verdict == ihc_pkg::V_FRAGMENT)
			== (out_item.more_fragments || out_item.fragment_offset != 13'd0)))
		else $error("fragment verdict disagrees with flags");

endmodule

bind ipv4_rx_header_check ihc_checker u_ihc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_item  (out_ch.item)
);
